[src/cewf_pkg.sv]
package cewf_pkg;

   // Field widths of the payload.
   localparam int unsigned STAMP_W  = 64;
   localparam int unsigned CHARGE_W = 16;
   localparam int unsigned CALIB_W  = 64;
   localparam int unsigned ENERGY_W = 48;
   localparam int unsigned STREAMS  = 4;

   // Gain times charge is signed Q.24 and needs 32 + 17 bits.
   localparam int unsigned PROD_W = 49;

   // Rounding from Q.24 to Q16.16: add half an LSB, then drop eight bits.
   localparam int unsigned FRAC_DROP  = 8;
   localparam int unsigned ROUND_BIAS = 128;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_CH0 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_CH1 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_CH2 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DET_SUMMED = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUM_LOW = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SUM_HIGH = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_LOW = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SINGLE_HIGH = 4'd7;

   // Reset value of the summed channel count.
   localparam logic [1:0] DET_SUMMED_RESET = 2'd3;

   // Advance mask with every stream moving on.
   localparam logic [STREAMS-1:0] MASK_ALL = 4'hF;

   // One input beat: the head records of the four streams.
   typedef struct packed {
      logic [STAMP_W-1:0]  stamp_a;
      logic [STAMP_W-1:0]  stamp_b;
      logic [STAMP_W-1:0]  stamp_c;
      logic [STAMP_W-1:0]  stamp_d;
      logic [CHARGE_W-1:0] charge_a;
      logic [CHARGE_W-1:0] charge_b;
      logic [CHARGE_W-1:0] charge_c;
      logic [CHARGE_W-1:0] charge_d;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [STREAMS-1:0]         advance_mask;
      logic                       coincident;
      logic                       accepted;
      logic signed [ENERGY_W-1:0] energy_total;
      logic [CHARGE_W-1:0]        timing_peak;
   } rsp_type;

   // Stage load enables shared by the lanes and the merge stage.
   typedef struct packed {
      logic load_s1;
      logic load_s2;
      logic load_s3;
   } pipe_ctrl_type;

endpackage

[src/cewf_lane.sv]
module cewf_lane (
   input  logic                                  clock,
   input  cewf_pkg::pipe_ctrl_type               ctrl,
   input  logic                                  lane_en,
   input  logic [cewf_pkg::CALIB_W-1:0]          calib,
   input  logic [cewf_pkg::CHARGE_W-1:0]         charge,
   input  logic signed [cewf_pkg::ENERGY_W-1:0]  bound_low,
   input  logic signed [cewf_pkg::ENERGY_W-1:0]  bound_high,
   output logic signed [cewf_pkg::ENERGY_W-1:0]  energy,
   output logic                                  in_bounds
);

   logic signed [31:0]                    gain;
   logic signed [31:0]                    offset;
   logic signed [cewf_pkg::PROD_W-1:0]    prod_in;
   logic signed [cewf_pkg::PROD_W-1:0]    prod_ff;
   logic                                  en_ff;
   logic signed [cewf_pkg::PROD_W-1:0]    rounded;
   logic signed [cewf_pkg::PROD_W-1:0]    scaled;
   logic signed [cewf_pkg::PROD_W-1:0]    shifted_sum;
   logic signed [cewf_pkg::ENERGY_W-1:0]  energy_raw;
   logic signed [cewf_pkg::ENERGY_W-1:0]  energy_in;
   logic                                  inb_in;
   logic signed [cewf_pkg::ENERGY_W-1:0]  energy_ff;
   logic                                  inb_ff;

   assign gain   = $signed(calib[63:32]);
   assign offset = $signed(calib[31:0]);

   // Stage 1: gain times charge, charge taken as a non-negative value.
   assign prod_in = gain * $signed({1'b0, charge});

   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         prod_ff <= prod_in;
         en_ff   <= lane_en;
      end
   end

   // Stage 2: round half up to Q16.16 with a floor shift, then add the offset.
   assign rounded     = prod_ff + cewf_pkg::PROD_W'(cewf_pkg::ROUND_BIAS);
   assign scaled      = rounded >>> cewf_pkg::FRAC_DROP;
   assign shifted_sum = scaled + cewf_pkg::PROD_W'(offset);
   assign energy_raw  = shifted_sum[cewf_pkg::ENERGY_W-1:0];

   // A channel outside the sum adds nothing and never fails the bounds.
   assign energy_in = en_ff ? energy_raw : '0;
   assign inb_in    = !en_ff || ((energy_raw >= bound_low) && (energy_raw <= bound_high));

   always_ff @(posedge clock) begin
      if (ctrl.load_s2) begin
         energy_ff <= energy_in;
         inb_ff    <= inb_in;
      end
   end

   assign energy    = energy_ff;
   assign in_bounds = inb_ff;

endmodule

[src/cewf_merge.sv]
module cewf_merge #(
   parameter int unsigned LANES = 1
) (
   input  logic                                          clock,
   input  cewf_pkg::pipe_ctrl_type                       ctrl,
   input  logic [LANES-1:0][cewf_pkg::ENERGY_W-1:0]      energy,
   input  logic [LANES-1:0]                              in_bounds,
   input  logic signed [cewf_pkg::ENERGY_W-1:0]          win_low,
   input  logic signed [cewf_pkg::ENERGY_W-1:0]          win_high,
   output logic signed [cewf_pkg::ENERGY_W-1:0]          energy_total,
   output logic                                          pass
);

   logic signed [cewf_pkg::ENERGY_W-1:0] sum_in;
   logic signed [cewf_pkg::ENERGY_W-1:0] sum_ff;
   logic                                 inb_ff;

   // Add the lane energies; disabled lanes already carry zero.
   always_comb begin
      sum_in = '0;
      for (int k = 0; k < LANES; k++) begin
         sum_in = sum_in + $signed(energy[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_s3) begin
         sum_ff <= sum_in;
         inb_ff <= &in_bounds;
      end
   end

   // The sum must lie strictly inside the window and every lane must be in bounds.
   assign energy_total = sum_ff;
   assign pass         = inb_ff && (win_low < sum_ff) && (sum_ff < win_high);

endmodule

[src/coincidence_energy_window_filter.sv]
// Coincidence filter with energy-sum window. Each req beat carries the head time stamp and
// long charge of four detector streams (stream 3 is the timing channel); each produces exactly
// one rsp beat with the advance mask, the coincidence flag, the accept decision, the summed
// calibrated energy in keV signed Q32.16 and the running peak of the timing-channel charge over
// coincidences. The block takes one beat per clock while req_stall is low; a beat passes through
// the per-lane signed 32 x 17 bit calibration multiply, the rounding and offset add, the lane
// sum, and the output register. req_stall rises only when all four stages hold results and
// rsp_stall is high. csr_ready is always high; registers are to be written only while the block
// is idle, which the block itself does not enforce, and indexes beyond 7 are ignored.
module coincidence_energy_window_filter #(
   parameter int unsigned ENERGY_CHANNELS = 3,
   parameter int unsigned STAMP_BITS      = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  cewf_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output cewf_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cewf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cewf_pkg::CALIB_W-1:0]          csr_data
);

   localparam logic [cewf_pkg::STAMP_W-1:0] STAMP_MASK =
      {cewf_pkg::STAMP_W{1'b1}} >> (cewf_pkg::STAMP_W - STAMP_BITS);
   localparam logic [1:0] LANES_MAX = 2'(ENERGY_CHANNELS);

   // Configuration registers.
   logic [cewf_pkg::CALIB_W-1:0]          calib_ff [ENERGY_CHANNELS];
   logic [1:0]                            det_summed_ff;
   logic signed [cewf_pkg::ENERGY_W-1:0]  sum_low_ff;
   logic signed [cewf_pkg::ENERGY_W-1:0]  sum_high_ff;
   logic signed [cewf_pkg::ENERGY_W-1:0]  single_low_ff;
   logic signed [cewf_pkg::ENERGY_W-1:0]  single_high_ff;
   logic                                  csr_we;

   // Pipeline control.
   cewf_pkg::pipe_ctrl_type ctrl;
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;
   logic ready_out;
   logic ready_s3;
   logic ready_s2;
   logic ready_s1;

   // Stamp comparison and advance mask.
   logic [cewf_pkg::STAMP_W-1:0]  s0;
   logic [cewf_pkg::STAMP_W-1:0]  s1;
   logic [cewf_pkg::STAMP_W-1:0]  s2;
   logic [cewf_pkg::STAMP_W-1:0]  s3;
   logic                          coinc_in;
   logic [cewf_pkg::STREAMS-1:0]  mask_in;
   logic [1:0]                    n_eff;
   logic [ENERGY_CHANNELS-1:0]    lane_en;
   logic [ENERGY_CHANNELS-1:0][cewf_pkg::CHARGE_W-1:0] lane_charge;

   // Stage registers for the side-band fields.
   logic [cewf_pkg::CHARGE_W-1:0]  peak_in;
   logic [cewf_pkg::CHARGE_W-1:0]  peak_ff;
   logic [cewf_pkg::STREAMS-1:0]   mask_s1_ff;
   logic [cewf_pkg::STREAMS-1:0]   mask_s2_ff;
   logic [cewf_pkg::STREAMS-1:0]   mask_s3_ff;
   logic                           coinc_s1_ff;
   logic                           coinc_s2_ff;
   logic                           coinc_s3_ff;
   logic [cewf_pkg::CHARGE_W-1:0]  peak_s1_ff;
   logic [cewf_pkg::CHARGE_W-1:0]  peak_s2_ff;
   logic [cewf_pkg::CHARGE_W-1:0]  peak_s3_ff;

   // Lane and merge results.
   logic [ENERGY_CHANNELS-1:0][cewf_pkg::ENERGY_W-1:0] lane_energy;
   logic [ENERGY_CHANNELS-1:0]                         lane_inb;
   logic signed [cewf_pkg::ENERGY_W-1:0]               total;
   logic                                               pass;
   cewf_pkg::rsp_type                                  rsp_in;
   cewf_pkg::rsp_type                                  rsp_data_ff;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ENERGY_CHANNELS; k++) begin
            calib_ff[k] <= '0;
         end
         det_summed_ff  <= cewf_pkg::DET_SUMMED_RESET;
         sum_low_ff     <= '0;
         sum_high_ff    <= '0;
         single_low_ff  <= '0;
         single_high_ff <= '0;
      end else if (csr_we) begin
         for (int k = 0; k < ENERGY_CHANNELS; k++) begin
            if (csr_index == cewf_pkg::CSR_CALIB_CH0 + cewf_pkg::CSR_IDX_W'(k)) begin
               calib_ff[k] <= csr_data;
            end
         end
         unique case (csr_index)
            cewf_pkg::CSR_DET_SUMMED:  det_summed_ff  <= csr_data[1:0];
            cewf_pkg::CSR_SUM_LOW:     sum_low_ff     <= $signed(csr_data[cewf_pkg::ENERGY_W-1:0]);
            cewf_pkg::CSR_SUM_HIGH:    sum_high_ff    <= $signed(csr_data[cewf_pkg::ENERGY_W-1:0]);
            cewf_pkg::CSR_SINGLE_LOW:  single_low_ff  <= $signed(csr_data[cewf_pkg::ENERGY_W-1:0]);
            cewf_pkg::CSR_SINGLE_HIGH: single_high_ff <= $signed(csr_data[cewf_pkg::ENERGY_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // A stage takes a beat when it is empty or its content moves on this cycle.
   assign ready_out = !rsp_valid_ff || !rsp_stall;
   assign ready_s3  = !s3_valid_ff || ready_out;
   assign ready_s2  = !s2_valid_ff || ready_s3;
   assign ready_s1  = !s1_valid_ff || ready_s2;
   assign req_stall = !ready_s1;

   assign ctrl.load_s1 = req_valid && ready_s1;
   assign ctrl.load_s2 = s1_valid_ff && ready_s2;
   assign ctrl.load_s3 = s2_valid_ff && ready_s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready_s1) begin
            s1_valid_ff <= req_valid;
         end
         if (ready_s2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ready_s3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (ready_out) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Only the low STAMP_BITS bits of each stamp take part in the comparison.
   assign s0 = req_data.stamp_a & STAMP_MASK;
   assign s1 = req_data.stamp_b & STAMP_MASK;
   assign s2 = req_data.stamp_c & STAMP_MASK;
   assign s3 = req_data.stamp_d & STAMP_MASK;
   assign coinc_in = (s0 == s1) && (s0 == s2) && (s0 == s3);

   // Merge rule: walk 1..3 flagging streams older than 0; a younger one flags 0 and stops.
   always_comb begin
      mask_in = '0;
      if (coinc_in) begin
         mask_in = cewf_pkg::MASK_ALL;
      end else if (s0 < s1) begin
         mask_in[0] = 1'b1;
      end else begin
         mask_in[1] = (s0 > s1);
         if (s0 < s2) begin
            mask_in[0] = 1'b1;
         end else begin
            mask_in[2] = (s0 > s2);
            if (s0 < s3) begin
               mask_in[0] = 1'b1;
            end else begin
               mask_in[3] = (s0 > s3);
            end
         end
      end
   end

   // Clamp the summed channel count to 1..ENERGY_CHANNELS.
   always_comb begin
      if (det_summed_ff == 2'd0) begin
         n_eff = 2'd1;
      end else if (det_summed_ff > LANES_MAX) begin
         n_eff = LANES_MAX;
      end else begin
         n_eff = det_summed_ff;
      end
   end

   // Timing-channel peak follows coincidences in beat order.
   assign peak_in = (coinc_in && (req_data.charge_d > peak_ff)) ? req_data.charge_d : peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else if (ctrl.load_s1) begin
         peak_ff <= peak_in;
      end
   end

   // Side-band fields ride along with the lane stages.
   always_ff @(posedge clock) begin
      if (ctrl.load_s1) begin
         mask_s1_ff  <= mask_in;
         coinc_s1_ff <= coinc_in;
         peak_s1_ff  <= peak_in;
      end
      if (ctrl.load_s2) begin
         mask_s2_ff  <= mask_s1_ff;
         coinc_s2_ff <= coinc_s1_ff;
         peak_s2_ff  <= peak_s1_ff;
      end
      if (ctrl.load_s3) begin
         mask_s3_ff  <= mask_s2_ff;
         coinc_s3_ff <= coinc_s2_ff;
         peak_s3_ff  <= peak_s2_ff;
      end
   end

   // Charges of the energy channels, in stream order.
   always_comb begin
      for (int k = 0; k < ENERGY_CHANNELS; k++) begin
         case (k)
            0:       lane_charge[k] = req_data.charge_a;
            1:       lane_charge[k] = req_data.charge_b;
            default: lane_charge[k] = req_data.charge_c;
         endcase
      end
   end

   // One calibration lane per energy channel.
   for (genvar k = 0; k < ENERGY_CHANNELS; k++) begin : g_lane
      assign lane_en[k] = coinc_in && (2'(k) < n_eff);

      cewf_lane u_lane (
         .clock      (clock),
         .ctrl       (ctrl),
         .lane_en    (lane_en[k]),
         .calib      (calib_ff[k]),
         .charge     (lane_charge[k]),
         .bound_low  (single_low_ff),
         .bound_high (single_high_ff),
         .energy     (lane_energy[k]),
         .in_bounds  (lane_inb[k])
      );
   end

   cewf_merge #(
      .LANES (ENERGY_CHANNELS)
   ) u_merge (
      .clock        (clock),
      .ctrl         (ctrl),
      .energy       (lane_energy),
      .in_bounds    (lane_inb),
      .win_low      (sum_low_ff),
      .win_high     (sum_high_ff),
      .energy_total (total),
      .pass         (pass)
   );

   // Output register.
   always_comb begin
      rsp_in.advance_mask = mask_s3_ff;
      rsp_in.coincident   = coinc_s3_ff;
      rsp_in.accepted     = coinc_s3_ff && pass;
      rsp_in.energy_total = total;
      rsp_in.timing_peak  = peak_s3_ff;
   end

   always_ff @(posedge clock) begin
      if (ready_out && s3_valid_ff) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_coinc_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.coincident |-> !rsp_data.accepted && rsp_data.energy_total == '0)
      else $error("non-coincident beat carries an accept or an energy");

   a_coinc_full_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.coincident |-> rsp_data.advance_mask == cewf_pkg::MASK_ALL)
      else $error("coincident beat does not advance every stream");

   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> peak_ff >= $past(peak_ff))
      else $error("timing peak decreased");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled while the pipeline has room");
`endif

endmodule
